// ===== rtl/core/rpfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpfm_pkg
// Shared types and constants of the recent post feed merger.
// ----------------------------------------------------------------------------
package rpfm_pkg;
	localparam int USERS      = 16;
	localparam int FEED_DEPTH = 10;
	localparam int RING_LEN   = 10;
	localparam int UW         = $clog2(USERS);
	localparam int SW         = $clog2(RING_LEN);
	localparam int NW         = $clog2(FEED_DEPTH + 1);
	localparam int AW         = $clog2(USERS * RING_LEN);
	localparam int DEPTH      = USERS * RING_LEN;

	localparam logic [1:0] REQ_POST     = 2'd0;
	localparam logic [1:0] REQ_FEED     = 2'd1;
	localparam logic [1:0] REQ_FOLLOW   = 2'd2;
	localparam logic [1:0] REQ_UNFOLLOW = 2'd3;

	typedef struct packed {
		logic [31:0] stamp;
		logic [15:0] id;
	} entry_t;

	// scan unit control from the sequencer
	typedef struct packed {
		logic clear;   // start a new pass
		logic check;   // compare the entry read last cycle
		logic bounded; // apply the stamp bound
	} scan_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/rpfm_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpfm_scan
// Shared compare unit: keeps the newest entry, below the bound when bounded, in one pass.
// ----------------------------------------------------------------------------
module rpfm_scan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpfm_pkg::scan_ctl_t ctl,
	input  wire rpfm_pkg::entry_t   rd,
	input  wire logic [31:0]        bound,
	output logic                    found,
	output rpfm_pkg::entry_t        best
);
	logic hit;
	assign hit = (!ctl.bounded || rd.stamp < bound) && (!found || rd.stamp > best.stamp);

	// running best of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.clear) begin
			found <= 1'b0;
		end else if (ctl.check && hit) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.check && hit && !ctl.clear) best <= rd;
	end
endmodule
`default_nettype wire

// ===== rtl/core/recent_post_feed_merger.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// recent_post_feed_merger
// Per-user post rings, follow matrix, newest-first feed merge.
// Post/follow/unfollow: the accepting edge moves to ST_ACK, which strobes the
// result; the next request can be accepted in the cycle it is on the ports.
// Feed: passes over all USERS*RING_LEN ring slots, one entry compared per cycle
// through the shared scan unit. A found post is held until the next pass shows
// whether it is last. At most FEED_DEPTH passes, then the final result from ST_ACK.
// Reset clears counts, heads, follow bits and the post clock at once.
// ----------------------------------------------------------------------------
module recent_post_feed_merger (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  user_id,
	input  wire logic [3:0]  other_user,
	input  wire logic [15:0] post_id,
	output logic             strobe,
	output logic [15:0]      item_id,
	output logic             has_item,
	output logic             last,
	output logic             status
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_ACK  = 4'b1000
	} state_t;

	state_t state_q;
	rpfm_pkg::entry_t mem [rpfm_pkg::DEPTH];
	rpfm_pkg::entry_t rd_q;
	logic [3:0] cnt_q  [rpfm_pkg::USERS];
	logic [3:0] head_q [rpfm_pkg::USERS];
	logic [rpfm_pkg::USERS-1:0] fol_q [rpfm_pkg::USERS];
	logic [31:0] clk_cnt_q;
	logic [31:0] bound_q;
	logic bounded_q;
	logic [3:0] user_q;
	logic [rpfm_pkg::UW-1:0] v_q;
	logic [rpfm_pkg::SW-1:0] j_q;
	logic valid_q;
	logic [rpfm_pkg::NW-1:0] n_q;
	logic ack_st_q;
	logic done_q;
	logic pend_q;
	logic [15:0] held_q;
	rpfm_pkg::scan_ctl_t ctl;
	logic found;
	rpfm_pkg::entry_t best;

	// address of the j-th newest slot of user v
	logic [rpfm_pkg::SW-1:0] slot;
	logic [rpfm_pkg::SW:0] hm;
	logic take;
	assign hm = {1'b0, head_q[v_q][rpfm_pkg::SW-1:0]} + (rpfm_pkg::SW+1)'(rpfm_pkg::RING_LEN - 1)
		- {1'b0, j_q};
	assign slot = (hm >= (rpfm_pkg::SW+1)'(rpfm_pkg::RING_LEN)) ?
		rpfm_pkg::SW'(hm - (rpfm_pkg::SW+1)'(rpfm_pkg::RING_LEN)) : rpfm_pkg::SW'(hm);
	assign take = ((v_q == user_q) || fol_q[user_q][v_q]) && (j_q < cnt_q[v_q]);

	logic [rpfm_pkg::AW-1:0] ra;
	assign ra = rpfm_pkg::AW'(v_q) * rpfm_pkg::AW'(rpfm_pkg::RING_LEN) + rpfm_pkg::AW'(slot);

	logic [rpfm_pkg::AW-1:0] wa;
	assign wa = rpfm_pkg::AW'(user_id) * rpfm_pkg::AW'(rpfm_pkg::RING_LEN)
		+ rpfm_pkg::AW'(head_q[user_id][rpfm_pkg::SW-1:0]);

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	logic scan_end;
	assign scan_end = (v_q == rpfm_pkg::UW'(rpfm_pkg::USERS - 1))
		&& (j_q == rpfm_pkg::SW'(rpfm_pkg::RING_LEN - 1));

	// a new pass starts on accept and once the finished pass has been evaluated
	assign ctl.clear   = accept || (state_q == ST_EVAL && !done_q);
	assign ctl.check   = valid_q;
	assign ctl.bounded = bounded_q;

	rpfm_scan u_scan (.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd(rd_q),
		.bound(bound_q), .found(found), .best(best));

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && req_type == rpfm_pkg::REQ_POST && clk_cnt_q != '1)
			mem[wa] <= '{stamp: clk_cnt_q + 32'd1, id: post_id};
		rd_q <= mem[ra];
	end

	// sequencer, per-user state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int u = 0; u < rpfm_pkg::USERS; u++) begin
				cnt_q[u] <= '0;
				head_q[u] <= '0;
				fol_q[u] <= '0;
			end
			clk_cnt_q <= '0;
			bounded_q <= 1'b0;
			bound_q <= '0;
			v_q <= '0;
			j_q <= '0;
			valid_q <= 1'b0;
			n_q <= '0;
			ack_st_q <= 1'b0;
			user_q <= '0;
			strobe <= 1'b0;
			done_q <= 1'b0;
			pend_q <= 1'b0;
			held_q <= '0;
			item_id <= '0;
			has_item <= 1'b0;
			last <= 1'b0;
			status <= 1'b0;
		end else begin
			strobe <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						user_q <= user_id;
						ack_st_q <= 1'b0;
						v_q <= '0;
						j_q <= '0;
						valid_q <= 1'b0;
						n_q <= '0;
						bounded_q <= 1'b0;
						pend_q <= 1'b0;
						case (req_type)
							rpfm_pkg::REQ_POST: begin
								if (clk_cnt_q == '1) begin
									ack_st_q <= 1'b1;
								end else begin
									clk_cnt_q <= clk_cnt_q + 32'd1;
									head_q[user_id] <= (head_q[user_id] ==
										4'(rpfm_pkg::RING_LEN - 1)) ? 4'd0 : head_q[user_id] + 4'd1;
									if (cnt_q[user_id] < 4'(rpfm_pkg::RING_LEN))
										cnt_q[user_id] <= cnt_q[user_id] + 4'd1;
								end
								state_q <= ST_ACK;
							end
							rpfm_pkg::REQ_FEED: state_q <= ST_SCAN;
							rpfm_pkg::REQ_FOLLOW, rpfm_pkg::REQ_UNFOLLOW: begin
								fol_q[user_id][other_user] <= (req_type == rpfm_pkg::REQ_FOLLOW);
								state_q <= ST_ACK;
							end
							default: state_q <= ST_ACK;
						endcase
					end
				end
				ST_SCAN: begin
					valid_q <= take;
					if (scan_end) begin
						state_q <= ST_EVAL;
						done_q <= 1'b1;
					end else if (j_q == rpfm_pkg::SW'(rpfm_pkg::RING_LEN - 1)) begin
						j_q <= '0;
						v_q <= v_q + rpfm_pkg::UW'(1);
					end else begin
						j_q <= j_q + rpfm_pkg::SW'(1);
					end
				end
				ST_EVAL: begin
					// wait while done_q is set, until the last compare has landed
					if (!done_q) begin
						v_q <= '0;
						j_q <= '0;
						valid_q <= 1'b0;
						if (found) begin
							// the held post is not last: send it, hold the new one
							if (pend_q) begin
								strobe <= 1'b1;
								item_id <= held_q;
								has_item <= 1'b1;
								last <= 1'b0;
								status <= 1'b0;
							end
							pend_q <= 1'b1;
							held_q <= best.id;
							bound_q <= best.stamp;
							n_q <= n_q + rpfm_pkg::NW'(1);
							bounded_q <= 1'b1;
							state_q <= (n_q == rpfm_pkg::NW'(rpfm_pkg::FEED_DEPTH - 1)) ?
								ST_ACK : ST_SCAN;
						end else begin
							state_q <= ST_ACK;
						end
					end else begin
						valid_q <= 1'b0;
						done_q <= 1'b0;
					end
				end
				ST_ACK: begin
					// final result: held post, empty feed or acknowledge
					strobe <= 1'b1;
					item_id <= pend_q ? held_q : 16'd0;
					has_item <= pend_q;
					last <= 1'b1;
					status <= ack_st_q && !pend_q;
					pend_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// feed result count never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= rpfm_pkg::NW'(rpfm_pkg::FEED_DEPTH)) else $error("feed overrun");
	// a strobe only follows an ack or an evaluation
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_ACK || state_q == ST_EVAL)) else $error("stray strobe");
	// the post clock never wraps
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(clk_cnt_q) == '1 |-> clk_cnt_q == '1) else $error("clock wrapped");
	// a feed post never carries an error status
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && has_item |-> !status) else $error("post with error status");
endmodule
`default_nettype wire
